// ----- hdl/profiled_motion_power_controller_unit_defines.svh -----
// assertion macros shared by the controller files
`ifndef PROFILED_MOTION_POWER_CONTROLLER_UNIT_DEFINES_SVH
`define PROFILED_MOTION_POWER_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTH
// condition holds in the same cycle
`define PMPC_ASSERT_NOW(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("pmpc assertion failed");
// condition holds in the next cycle
`define PMPC_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("pmpc assertion failed");
`else
`define PMPC_ASSERT_NOW(label, a, b)
`define PMPC_ASSERT_NEXT(label, a, b)
`endif

`endif

// ----- hdl/pmpc_pkg.sv -----
package pmpc_pkg;

   // controller constants
   localparam int POWER_MAX   = 127;
   localparam int BREAKPOINTS = 4;
   localparam int SLEW_STEP   = 20;
   localparam int BASE_POWER  = 0;

   localparam int POWER_LIMIT = (POWER_MAX > 127) ? 127 : POWER_MAX;
   localparam int BP_COUNT    = (BREAKPOINTS > 4) ? 4 : ((BREAKPOINTS < 1) ? 1 : BREAKPOINTS);

   // divider geometry
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // register indexes
   localparam logic [2:0] CSR_BP0         = 3'd0;
   localparam logic [2:0] CSR_BP1         = 3'd1;
   localparam logic [2:0] CSR_BP2         = 3'd2;
   localparam logic [2:0] CSR_BP3         = 3'd3;
   localparam logic [2:0] CSR_INIT_POWER  = 3'd4;
   localparam logic [2:0] CSR_SPEED_GAIN  = 3'd5;
   localparam logic [2:0] CSR_ERROR_GAIN  = 3'd6;
   localparam logic [2:0] CSR_SPEED_CAP   = 3'd7;

   // profile lookup selectors
   localparam logic [1:0] LK_ERR  = 2'd0;
   localparam logic [1:0] LK_PRED = 2'd1;
   localparam logic [1:0] LK_TGT  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEL,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ACC,
      ST_SQ,
      ST_STOP,
      ST_MI,
      ST_MD,
      ST_PWR
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [15:0] den;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quot;
   } div_rsp_type;

endpackage

// ----- hdl/profiled_motion_power_controller_unit.sv -----
// Profiled motion power controller. Each transfer on the req_ channel is one control
// tick carrying the signed position error; exactly one result follows on the rsp_
// channel with the new motor power, the stop flag, the measured speed and the
// clamped ideal speed. Each tick runs three profile lookups (at the error, at the
// predicted error and at the target), each mostly in the shared 32-step restoring
// divider, and then pushes the remaining products through one shared 18x18
// multiplier. One tick is worked at a time; req_stall is high until the sequencer
// is back in idle, so a new tick is accepted only after the previous result has been
// loaded into the output register, and that load waits while an earlier result is
// still stalled there. Registers are written through the csr_ port while the block
// is idle; the user must keep to this, as the block does not enforce it. csr_ready is always high.
`include "profiled_motion_power_controller_unit_defines.svh"

module profiled_motion_power_controller_unit import pmpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_position_error,
   input  logic               req_first_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [7:0]  rsp_motor_power,
   output logic               rsp_done_res,
   output logic signed [16:0] rsp_measured_speed,
   output logic signed [16:0] rsp_ideal_speed,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   state_type state_ff, state_in;

   // configuration
   logic [31:0] bp_ff [4];
   logic [31:0] bp_in [4];
   logic [6:0]  init_pow_ff, init_pow_in;
   logic [11:0] sg_ff, sg_in;
   logic [11:0] seg_ff, seg_in;
   logic [15:0] cap_ff, cap_in;

   // motion state
   logic signed [15:0] prev_ff, prev_in;
   logic signed [15:0] start_ff, start_in;
   logic signed [7:0]  held_ff, held_in;
   logic               await_ff, await_in;

   // tick working registers
   logic signed [15:0] err_ff, err_in;
   logic signed [16:0] act_ff, act_in;
   logic signed [18:0] pred_ff, pred_in;
   logic [1:0]         lk_ff, lk_in;
   logic [15:0]        lo_s_ff, lo_s_in;
   logic signed [16:0] delta_ff, delta_in;
   logic [15:0]        offs_ff, offs_in;
   logic [15:0]        span_ff, span_in;
   logic               direct_ff, direct_in;
   logic [15:0]        dval_ff, dval_in;
   logic signed [35:0] prod_ff, prod_in;
   logic signed [35:0] acc_ff, acc_in;
   logic signed [16:0] p0_ff, p0_in;
   logic signed [16:0] p1_ff, p1_in;
   logic [15:0]        ptgt_ff, ptgt_in;
   logic signed [16:0] ideal_ff, ideal_in;
   logic               done_ff, done_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]  out_power_ff, out_power_in;
   logic               out_done_ff, out_done_in;
   logic signed [16:0] out_meas_ff, out_meas_in;
   logic signed [16:0] out_ideal_ff, out_ideal_in;

   logic               accept;
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] mul_p;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   pmpc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL: begin
            mul_a = 18'(delta_ff);
            mul_b = $signed({2'b00, offs_ff});
         end
         ST_SQ: begin
            mul_a = 18'(act_ff);
            mul_b = 18'(act_ff);
         end
         ST_MI: begin
            mul_a = 18'(ideal_ff);
            mul_b = $signed({6'b0, sg_ff});
         end
         ST_MD: begin
            mul_a = 18'(ideal_ff) - 18'(act_ff);
            mul_b = $signed({6'b0, seg_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // sequencer and datapath
   always_comb begin
      logic               first;
      logic signed [16:0] act_v;
      logic signed [18:0] dsrc;
      logic [17:0]        dmag;
      logic               found;
      logic [15:0]        lo_p, lo_s, hp, hs;
      logic [17:0]        offs_w;
      logic [16:0]        q17, qv, val;
      logic [15:0]        mag;
      logic signed [16:0] smag, sres;
      logic               rneg, rzero;
      logic signed [17:0] sum;
      logic signed [16:0] avg, avg_mag;
      logic signed [33:0] half_s, sp, sp_mag;
      logic [16:0]        err_mag, act_mag;
      logic [15:0]        tgt;
      logic               near, opp, c1, c2;
      logic signed [37:0] acc, pq, hi, lo, lim, base_t;

      state_in     = state_ff;
      bp_in        = bp_ff;
      init_pow_in  = init_pow_ff;
      sg_in        = sg_ff;
      seg_in       = seg_ff;
      cap_in       = cap_ff;
      prev_in      = prev_ff;
      start_in     = start_ff;
      held_in      = held_ff;
      await_in     = await_ff;
      err_in       = err_ff;
      act_in       = act_ff;
      pred_in      = pred_ff;
      lk_in        = lk_ff;
      lo_s_in      = lo_s_ff;
      delta_in     = delta_ff;
      offs_in      = offs_ff;
      span_in      = span_ff;
      direct_in    = direct_ff;
      dval_in      = dval_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      ptgt_in      = ptgt_ff;
      ideal_in     = ideal_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_power_in = out_power_ff;
      out_done_in  = out_done_ff;
      out_meas_in  = out_meas_ff;
      out_ideal_in = out_ideal_ff;
      div_req.start = 1'b0;
      div_req.num   = prod_ff[35] ? 32'(-prod_ff) : prod_ff[31:0];
      div_req.den   = span_ff;

      // configuration write
      if (csr_valid) begin
         case (csr_index)
            CSR_BP0:        bp_in[0]    = csr_data;
            CSR_BP1:        bp_in[1]    = csr_data;
            CSR_BP2:        bp_in[2]    = csr_data;
            CSR_BP3:        bp_in[3]    = csr_data;
            CSR_INIT_POWER: init_pow_in = csr_data[6:0];
            CSR_SPEED_GAIN: sg_in       = csr_data[11:0];
            CSR_ERROR_GAIN: seg_in      = csr_data[11:0];
            CSR_SPEED_CAP:  cap_in      = csr_data[15:0];
            default: ;
         endcase
      end

      // lookup distance
      case (lk_ff)
         LK_ERR:  dsrc = 19'(err_ff);
         LK_PRED: dsrc = pred_ff;
         default: dsrc = $signed({3'b000, bp_ff[0][31:16]});
      endcase
      dmag = dsrc[18] ? 18'(-dsrc) : dsrc[17:0];

      // segment search
      found = 1'b0;
      lo_p  = '0;
      lo_s  = '0;
      hp    = '0;
      hs    = '0;
      for (int i = 0; i < BP_COUNT; i++) begin
         if (!found) begin
            if (dmag <= {2'b00, bp_ff[i][31:16]}) begin
               found = 1'b1;
               hp    = bp_ff[i][31:16];
               hs    = bp_ff[i][15:0];
            end else begin
               lo_p = bp_ff[i][31:16];
               lo_s = bp_ff[i][15:0];
            end
         end
      end
      offs_w = dmag - {2'b00, lo_p};

      // lookup result
      q17   = div_rsp.quot[16:0];
      qv    = prod_ff[35] ? (17'd0 - q17) : q17;
      val   = {1'b0, lo_s_ff} + qv;
      mag   = direct_ff ? dval_ff : val[15:0];
      smag  = $signed({1'b0, mag});
      rneg  = (lk_ff == LK_ERR) ? (err_ff < 0) : (pred_ff < 0);
      rzero = (lk_ff == LK_ERR) ? (err_ff == 0) : (pred_ff == 0);
      sres  = rzero ? 17'sd0 : (rneg ? -smag : smag);

      // ideal speed and stop test
      sum     = 18'(p0_ff) + 18'(p1_ff);
      avg     = 17'((sum + (sum[17] ? 18'sd1 : 18'sd0)) >>> 1);
      avg_mag = avg[16] ? -avg : avg;
      tgt     = bp_ff[0][31:16];
      err_mag = err_ff[15] ? 17'(-(17'(err_ff))) : 17'(err_ff);
      act_mag = act_ff[16] ? 17'(-act_ff) : 17'(act_ff);
      half_s  = $signed({3'b000, prod_ff[31:1]});
      sp      = act_ff[16] ? (34'(err_ff) + half_s) : (34'(err_ff) - half_s);
      sp_mag  = sp[33] ? -sp : sp;
      near    = err_mag <= {1'b0, tgt};
      opp     = (start_ff < 0 && err_ff > 0) || (start_ff > 0 && err_ff < 0);
      c1      = sp_mag <= $signed({19'b0, tgt[15:1]});
      c2      = act_mag <= {2'b00, ptgt_ff[15:1]};

      // power
      base_t = (err_ff < 0) ? -38'(BASE_POWER * 256) :
               ((err_ff > 0) ? 38'(BASE_POWER * 256) : 38'sd0);
      acc    = 38'(acc_ff) + 38'(prod_ff) + base_t;
      pq     = (acc + (acc[37] ? 38'sd255 : 38'sd0)) >>> 8;
      hi     = 38'(held_ff) + 38'(SLEW_STEP);
      lo     = 38'(held_ff) - 38'(SLEW_STEP);
      lim    = 38'(POWER_LIMIT);
      if (pq > hi) begin
         pq = hi;
      end else if (pq < lo) begin
         pq = lo;
      end
      if (pq > lim) begin
         pq = lim;
      end else if (pq < -lim) begin
         pq = -lim;
      end

      first = await_ff || req_first_sample;
      act_v = first ? 17'sd0 : (17'(prev_ff) - 17'(req_position_error));

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               err_in   = req_position_error;
               act_in   = act_v;
               pred_in  = 19'(req_position_error) - (19'(act_v) <<< 1);
               prev_in  = req_position_error;
               await_in = 1'b0;
               lk_in    = LK_ERR;
               if (first) begin
                  start_in = req_position_error;
                  held_in  = (req_position_error < 0) ? -$signed({1'b0, init_pow_ff}) :
                             ((req_position_error > 0) ? $signed({1'b0, init_pow_ff}) : 8'sd0);
               end
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            lo_s_in   = lo_s;
            delta_in  = $signed({1'b0, hs}) - $signed({1'b0, lo_s});
            offs_in   = offs_w[15:0];
            span_in   = hp - lo_p;
            direct_in = !found || (hp <= lo_p);
            dval_in   = found ? hs : lo_s;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mul_p;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            case (lk_ff)
               LK_ERR: begin
                  p0_in    = sres;
                  lk_in    = LK_PRED;
                  state_in = ST_SEL;
               end
               LK_PRED: begin
                  p1_in    = sres;
                  lk_in    = LK_TGT;
                  state_in = ST_SEL;
               end
               default: begin
                  ptgt_in  = mag;
                  state_in = ST_SQ;
               end
            endcase
         end
         ST_SQ: begin
            prod_in  = mul_p;
            state_in = ST_STOP;
         end
         ST_STOP: begin
            if (avg_mag > $signed({1'b0, cap_ff})) begin
               ideal_in = avg[16] ? -$signed({1'b0, cap_ff}) : $signed({1'b0, cap_ff});
            end else begin
               ideal_in = avg;
            end
            done_in  = (near || opp) && (c1 || c2);
            state_in = ST_MI;
         end
         ST_MI: begin
            prod_in  = mul_p;
            state_in = ST_MD;
         end
         ST_MD: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = ST_PWR;
         end
         ST_PWR: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (!done_ff) begin
                  held_in = pq[7:0];
               end
               out_power_in = done_ff ? held_ff : pq[7:0];
               out_done_in  = done_ff;
               out_meas_in  = act_ff;
               out_ideal_in = ideal_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lk_ff        <= LK_ERR;
         bp_ff[0]     <= 32'd2621450;
         bp_ff[1]     <= 32'd9830420;
         bp_ff[2]     <= 32'd19660830;
         bp_ff[3]     <= 32'd314573040;
         init_pow_ff  <= 7'd45;
         sg_ff        <= 12'd461;
         seg_ff       <= 12'd1024;
         cap_ff       <= 16'd240;
         prev_ff      <= '0;
         start_ff     <= '0;
         held_ff      <= '0;
         await_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lk_ff        <= lk_in;
         bp_ff        <= bp_in;
         init_pow_ff  <= init_pow_in;
         sg_ff        <= sg_in;
         seg_ff       <= seg_in;
         cap_ff       <= cap_in;
         prev_ff      <= prev_in;
         start_ff     <= start_in;
         held_ff      <= held_in;
         await_ff     <= await_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      act_ff       <= act_in;
      pred_ff      <= pred_in;
      lo_s_ff      <= lo_s_in;
      delta_ff     <= delta_in;
      offs_ff      <= offs_in;
      span_ff      <= span_in;
      direct_ff    <= direct_in;
      dval_ff      <= dval_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      ptgt_ff      <= ptgt_in;
      ideal_ff     <= ideal_in;
      done_ff      <= done_in;
      out_power_ff <= out_power_in;
      out_done_ff  <= out_done_in;
      out_meas_ff  <= out_meas_in;
      out_ideal_ff <= out_ideal_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor_power    = out_power_ff;
   assign rsp_done_res       = out_done_ff;
   assign rsp_measured_speed = out_meas_ff;
   assign rsp_ideal_speed    = out_ideal_ff;

   `PMPC_ASSERT_NEXT(a_accept_busy, accept, state_ff != ST_IDLE)
   `PMPC_ASSERT_NOW(a_power_range, rsp_valid_ff, out_power_ff != 8'sh80)
   `PMPC_ASSERT_NOW(a_div_wait_live, state_ff == ST_DIV_WAIT, div_rsp.busy || div_rsp.done)

endmodule

// ----- hdl/pmpc_div.sv -----
`include "profiled_motion_power_controller_unit_defines.svh"

module pmpc_div import pmpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [15:0]          rem_ff, rem_in;
   logic [31:0]          quot_ff, quot_in;
   logic [15:0]          den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // one restoring step per cycle
   always_comb begin
      logic [16:0] trial;
      logic [16:0] sub;
      logic        ge;
      trial   = {rem_ff, quot_ff[31]};
      sub     = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quot_in = div_req.num;
         den_in  = div_req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? sub[15:0] : trial[15:0];
         quot_in = {quot_ff[30:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

   `PMPC_ASSERT_NEXT(a_div_start_busy, div_req.start, busy_ff)
   `PMPC_ASSERT_NEXT(a_div_last_done, busy_ff && !div_req.start && cnt_ff == DIV_LAST, done_ff)
   `PMPC_ASSERT_NOW(a_div_done_idle, done_ff, !busy_ff)

endmodule
